// ===== rtl/grid_maze_path_counter_top_defines.svh =====
// ---------------------------------------------------------------------------
// Grid maze path counter: assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef GRID_MAZE_PATH_COUNTER_TOP_DEFINES_SVH
`define GRID_MAZE_PATH_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define GMPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, live through reset
`define GMPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GMPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/gmpc_pkg.sv =====
// ---------------------------------------------------------------------------
// Grid maze path counter: package
// Grid geometry, register map, microcode encoding and the microcode ROM.
// ---------------------------------------------------------------------------
package gmpc_pkg;

    // grid geometry
    localparam int GRID_ROWS  = 3;
    localparam int GRID_COLS  = 3;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int DEPTH_W    = $clog2(CELL_COUNT);

    // register map
    localparam int WALL_BITS  = 9;
    localparam int GOAL_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL = 2'd2;
    localparam logic [WALL_BITS-1:0] WALL_RESET     = 9'd12;
    localparam logic [GOAL_W-1:0]    GOAL_ROW_RESET = 2'd2;
    localparam logic [GOAL_W-1:0]    GOAL_COL_RESET = 2'd2;

    // result
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // move directions, tried in this order
    localparam int DIR_W = 3;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
    localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

    // microcode encoding
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_PROBE,
        UOP_PUSH,
        UOP_POP,
        UOP_COUNT,
        UOP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        UC_NEXT,
        UC_ALWAYS,
        UC_NO_START,
        UC_TRIVIAL,
        UC_EXHAUSTED,
        UC_BLOCKED,
        UC_HIT,
        UC_DEPTH_ZERO,
        UC_SAT_NEXT
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic start;
        logic trivial;
        logic exhausted;
        logic blocked;
        logic hit;
        logic depth_zero;
        logic sat_next;
    } t_flags;

    // program addresses
    localparam t_upc UPC_IDLE  = 4'd0;
    localparam t_upc UPC_CHECK = 4'd1;
    localparam t_upc UPC_PROBE = 4'd2;
    localparam t_upc UPC_EXH   = 4'd3;
    localparam t_upc UPC_BLK   = 4'd4;
    localparam t_upc UPC_HIT   = 4'd5;
    localparam t_upc UPC_PUSH  = 4'd6;
    localparam t_upc UPC_POP   = 4'd7;
    localparam t_upc UPC_LOOP  = 4'd8;
    localparam t_upc UPC_COUNT = 4'd9;
    localparam t_upc UPC_LOOP2 = 4'd10;
    localparam t_upc UPC_DONE  = 4'd11;

    // microcode ROM: a taken condition jumps to target, otherwise fall through
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        case (pc)
            UPC_IDLE:  w = '{UOP_LOAD,  UC_NO_START,   UPC_IDLE};
            UPC_CHECK: w = '{UOP_NOP,   UC_TRIVIAL,    UPC_DONE};
            UPC_PROBE: w = '{UOP_PROBE, UC_NEXT,       UPC_IDLE};
            UPC_EXH:   w = '{UOP_NOP,   UC_EXHAUSTED,  UPC_POP};
            UPC_BLK:   w = '{UOP_NOP,   UC_BLOCKED,    UPC_PROBE};
            UPC_HIT:   w = '{UOP_NOP,   UC_HIT,        UPC_COUNT};
            UPC_PUSH:  w = '{UOP_PUSH,  UC_ALWAYS,     UPC_PROBE};
            UPC_POP:   w = '{UOP_POP,   UC_DEPTH_ZERO, UPC_DONE};
            UPC_LOOP:  w = '{UOP_NOP,   UC_ALWAYS,     UPC_PROBE};
            UPC_COUNT: w = '{UOP_COUNT, UC_SAT_NEXT,   UPC_DONE};
            UPC_LOOP2: w = '{UOP_NOP,   UC_ALWAYS,     UPC_PROBE};
            UPC_DONE:  w = '{UOP_EMIT,  UC_ALWAYS,     UPC_IDLE};
            default:   w = '{UOP_NOP,   UC_ALWAYS,     UPC_IDLE};
        endcase
        return w;
    endfunction

    // row-major cell index
    function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        return CELL_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

// ===== rtl/gmpc_useq.sv =====
// ---------------------------------------------------------------------------
// Grid maze path counter: microcode sequencer
// Step counter, control ROM and conditional jump logic.
// ---------------------------------------------------------------------------
module gmpc_useq import gmpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uword,
    output logic   o_busy
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uword;
    logic   take;

    // control word for the current step
    assign uword   = ucode_rom(r_upc);
    assign o_uword = uword;
    assign o_busy  = (r_upc != UPC_IDLE);

    // jump condition select
    always_comb begin
        unique case (uword.cond)
            UC_NEXT:       take = 1'b0;
            UC_ALWAYS:     take = 1'b1;
            UC_NO_START:   take = !i_flags.start;
            UC_TRIVIAL:    take = i_flags.trivial;
            UC_EXHAUSTED:  take = i_flags.exhausted;
            UC_BLOCKED:    take = i_flags.blocked;
            UC_HIT:        take = i_flags.hit;
            UC_DEPTH_ZERO: take = i_flags.depth_zero;
            UC_SAT_NEXT:   take = i_flags.sat_next;
            default:       take = 1'b1;
        endcase
        n_upc = take ? uword.target : r_upc + 1'b1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== rtl/grid_maze_path_counter_top.sv =====
// ---------------------------------------------------------------------------
// Grid maze path counter
// Counts simple paths from a start cell to the goal cell by a microcoded
// depth-first backtracking walk over a small walled grid.
// ---------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  command   | start, busy                | i_start_row, i_start_col
//  result    | o_done (one-cycle strobe)  | o_path_count, o_count_saturated
//  config    | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  A command beat is taken when start is high and busy is low; busy then
//  stays high until the cycle after the o_done strobe.
//  A run steps through the start check, then per move tried a probe, the
//  exhausted, blocked and goal tests and a push into a free cell or a count
//  at the goal, a pop per cell backed out of, and the result; a start off the
//  grid or equal to the goal goes from the start check to the result.
//  Synchronous active-low reset restores the register reset values.
//  o_cfg_ready is always high; results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`include "grid_maze_path_counter_top_defines.svh"

module grid_maze_path_counter_top import gmpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_start_row,
    input  logic [1:0]            i_start_col,
    // result
    output logic                  o_done,
    output logic [COUNT_W-1:0]    o_path_count,
    output logic                  o_count_saturated,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [WALL_BITS-1:0] r_wall;
    logic [GOAL_W-1:0]    r_goal_row;
    logic [GOAL_W-1:0]    r_goal_col;

    // walk state
    logic [CELL_COUNT-1:0] r_visited;
    logic [DEPTH_W-1:0]    r_depth;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_trivial;
    logic [ROW_W-1:0]      r_row_stk [CELL_COUNT];
    logic [COL_W-1:0]      r_col_stk [CELL_COUNT];
    logic [DIR_W-1:0]      r_dir_stk [CELL_COUNT];

    // registered probe outcome
    logic             r_exh;
    logic             r_blk;
    logic             r_hit;
    logic [ROW_W-1:0] r_nb_row;
    logic [COL_W-1:0] r_nb_col;
    logic [CELL_W-1:0] r_nb_cell;

    // sequencer link
    t_uword uword;
    t_flags flags;

    // combinational helpers
    logic              goal_ok;
    logic [CELL_W-1:0] goal_cell;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [DIR_W-1:0]  cur_dir;
    logic [CELL_W-1:0] cur_cell;
    logic [ROW_W-1:0]  nb_row;
    logic [COL_W-1:0]  nb_col;
    logic [CELL_W-1:0] nb_cell;
    logic              nb_in;
    logic              nb_wall;
    logic              nb_blocked;
    logic              nb_hit;
    logic              cur_exh;
    logic              start_ok;
    logic              start_eq;
    logic [CELL_W-1:0] start_cell;
    logic              push_ok;
    logic [DEPTH_W-1:0] depth_up;
    logic              load_go;

    gmpc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword),
        .o_busy  (busy)
    );

    // goal and start decode
    assign goal_ok    = (int'(r_goal_row) < GRID_ROWS) && (int'(r_goal_col) < GRID_COLS);
    assign goal_cell  = cell_of(ROW_W'(r_goal_row), COL_W'(r_goal_col));
    assign start_ok   = (int'(i_start_row) < GRID_ROWS) && (int'(i_start_col) < GRID_COLS);
    assign start_eq   = start_ok && goal_ok && (i_start_row == r_goal_row)
                        && (i_start_col == r_goal_col);
    assign start_cell = cell_of(ROW_W'(i_start_row), COL_W'(i_start_col));
    assign load_go    = (uword.op == UOP_LOAD) && start;

    // top of stack
    assign cur_row  = r_row_stk[r_depth];
    assign cur_col  = r_col_stk[r_depth];
    assign cur_dir  = r_dir_stk[r_depth];
    assign cur_cell = cell_of(cur_row, cur_col);
    assign cur_exh  = (cur_dir >= DIR_END);

    // neighbor in the current direction; stays on the cell when off the grid
    always_comb begin
        nb_row = cur_row;
        nb_col = cur_col;
        nb_in  = 1'b0;
        case (cur_dir)
            DIR_UP: begin
                if (cur_row != '0) begin
                    nb_in  = 1'b1;
                    nb_row = cur_row - 1'b1;
                end
            end
            DIR_DOWN: begin
                if (int'(cur_row) < GRID_ROWS - 1) begin
                    nb_in  = 1'b1;
                    nb_row = cur_row + 1'b1;
                end
            end
            DIR_LEFT: begin
                if (cur_col != '0) begin
                    nb_in  = 1'b1;
                    nb_col = cur_col - 1'b1;
                end
            end
            DIR_RIGHT: begin
                if (int'(cur_col) < GRID_COLS - 1) begin
                    nb_in  = 1'b1;
                    nb_col = cur_col + 1'b1;
                end
            end
            default: begin
                nb_in = 1'b0;
            end
        endcase
    end

    // cells past the wall map are always open
    assign nb_cell    = cell_of(nb_row, nb_col);
    assign nb_wall    = (int'(nb_cell) < WALL_BITS) && r_wall[nb_cell];
    assign nb_blocked = !nb_in || nb_wall || r_visited[nb_cell];
    assign nb_hit     = goal_ok && (nb_cell == goal_cell);

    assign depth_up = r_depth + 1'b1;
    assign push_ok  = (int'(r_depth) + 1 < CELL_COUNT);

    // status to the sequencer
    assign flags = '{
        start:      start,
        trivial:    r_trivial,
        exhausted:  r_exh,
        blocked:    r_blk,
        hit:        r_hit,
        depth_zero: (r_depth == '0),
        sat_next:   (r_count == COUNT_MAX - 1'b1)
    };

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall     <= WALL_RESET;
            r_goal_row <= GOAL_ROW_RESET;
            r_goal_col <= GOAL_COL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WALL_MAP: r_wall     <= i_cfg_data[WALL_BITS-1:0];
                CFG_GOAL_ROW: r_goal_row <= i_cfg_data[GOAL_W-1:0];
                CFG_GOAL_COL: r_goal_col <= i_cfg_data[GOAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_depth   <= '0;
            r_count   <= '0;
            r_trivial <= 1'b0;
            r_exh     <= 1'b0;
            r_blk     <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            unique case (uword.op)
                UOP_LOAD: begin
                    if (start) begin
                        r_depth   <= '0;
                        r_count   <= start_eq ? COUNT_W'(1) : '0;
                        r_trivial <= !start_ok || start_eq;
                        r_visited <= start_ok ? (CELL_COUNT'(1) << start_cell) : '0;
                    end
                end
                UOP_PROBE: begin
                    r_exh <= cur_exh;
                    r_blk <= nb_blocked;
                    r_hit <= nb_hit;
                end
                UOP_PUSH: begin
                    if (push_ok) begin
                        r_depth              <= depth_up;
                        r_visited[r_nb_cell] <= 1'b1;
                    end
                end
                UOP_POP: begin
                    r_visited[cur_cell] <= 1'b0;
                    if (r_depth != '0) begin
                        r_depth <= r_depth - 1'b1;
                    end
                end
                UOP_COUNT: begin
                    r_count <= r_count + 1'b1;
                end
                UOP_EMIT: begin
                    r_visited <= '0;
                    r_depth   <= '0;
                end
                UOP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    // walk stacks and probe payload
    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_row_stk[0] <= ROW_W'(i_start_row);
            r_col_stk[0] <= COL_W'(i_start_col);
            r_dir_stk[0] <= DIR_UP;
        end
        if (uword.op == UOP_PROBE) begin
            r_nb_row  <= nb_row;
            r_nb_col  <= nb_col;
            r_nb_cell <= nb_cell;
            if (!cur_exh) begin
                r_dir_stk[r_depth] <= cur_dir + 1'b1;
            end
        end
        if ((uword.op == UOP_PUSH) && push_ok) begin
            r_row_stk[depth_up] <= r_nb_row;
            r_col_stk[depth_up] <= r_nb_col;
            r_dir_stk[depth_up] <= DIR_UP;
        end
    end

    // result beat
    assign o_done            = (uword.op == UOP_EMIT);
    assign o_path_count      = r_count;
    assign o_count_saturated = (r_count == COUNT_MAX);

    // checks
    `GMPC_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "done strobe held over")
    `GMPC_ASSERT(a_idle_clean, i_clk, i_rst_n, !busy |-> (r_visited == '0 && r_depth == '0), "walk state left over when idle")
    `GMPC_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "command accepted but block not busy")
    `GMPC_ASSERT(a_depth_range, i_clk, i_rst_n, r_depth <= DEPTH_W'(CELL_COUNT - 1), "walk depth past stack")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the grid maze path counter
// Sends start cells through the command handshake and reprograms the wall map
// and goal cell between phases. Each returned path count is checked against
// a known row's own count, else a local depth-first search of the same maze.
// ----------------------------------------------------------------------------
module tb_top import gmpc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1450;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] paths;
        logic               sat;
    } t_maze_result;

    typedef enum logic {ROW_CFG, ROW_CMD} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [1:0]            sr;
        logic [1:0]            sc;
        logic                  known;
        t_maze_result          want;
    } t_plan_row;

    localparam int PLAN_LEN = 29;

    // directed plan; known=1 rows carry their count, the rest are predicted
    t_plan_row plan [PLAN_LEN] = '{
        // reset maze: walls on cells 2 and 3, goal in the far corner
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd2, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd2, 2'd2, 1'b1, '{16'd1, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd3, 2'd1, 1'b1, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd1, 2'd3, 1'b1, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd3, 2'd3, 1'b1, '{16'd0, 1'b0}},
        // open maze
        '{ROW_CFG, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd1, 2'd1, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd2, 2'd1, 1'b0, '{16'd0, 1'b0}},
        // goal row off the grid
        '{ROW_CFG, CFG_GOAL_ROW, 9'h1FF, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b1, '{16'd0, 1'b0}},
        // goal at the origin, which is a wall
        '{ROW_CFG, CFG_GOAL_ROW, 9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CFG, CFG_GOAL_COL, 9'h1FC, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CFG, CFG_WALL_MAP, 9'h001, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd2, 2'd2, 1'b1, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b1, '{16'd1, 1'b0}},
        // every cell a wall, start walled in
        '{ROW_CFG, CFG_WALL_MAP, 9'h1FF, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd1, 2'd1, 1'b1, '{16'd0, 1'b0}},
        // a write to the spare index must not clear the walls
        '{ROW_CFG, CFG_UNUSED,   9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd1, 2'd1, 1'b1, '{16'd0, 1'b0}},
        // goal column off the grid
        '{ROW_CFG, CFG_GOAL_COL, 9'h003, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b1, '{16'd0, 1'b0}},
        // edge midpoints walled, then only the center walled
        '{ROW_CFG, CFG_WALL_MAP, 9'h0AA, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CFG, CFG_GOAL_ROW, 9'h002, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CFG, CFG_GOAL_COL, 9'h002, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CFG, CFG_WALL_MAP, 9'h010, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}},
        '{ROW_CMD, CFG_WALL_MAP, 9'h000, 2'd0, 2'd0, 1'b0, '{16'd0, 1'b0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_start_row;
    logic [1:0]            i_start_col;
    logic                  o_done;
    logic [COUNT_W-1:0]    o_path_count;
    logic                  o_count_saturated;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // local copy of the maze registers
    logic [WALL_BITS-1:0] wall_q;
    logic [GOAL_W-1:0]    goal_row_q;
    logic [GOAL_W-1:0]    goal_col_q;

    t_maze_result counts_due [$];
    int errors;

    grid_maze_path_counter_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_start_row       (i_start_row),
        .i_start_col       (i_start_col),
        .o_done            (o_done),
        .o_path_count      (o_path_count),
        .o_count_saturated (o_count_saturated),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // count simple paths from the start cell with the current maze settings
    function automatic t_maze_result predict_paths(input logic [1:0] sr,
                                                   input logic [1:0] sc);
        int unsigned          found;
        int                   depth;
        int                   cell_at [CELL_COUNT];
        logic [DIR_W-1:0]     dir_at [CELL_COUNT];
        logic [CELL_COUNT-1:0] on_walk;
        logic [DIR_W-1:0]     dir;
        int                   cur;
        int                   r;
        int                   c;
        int                   nxt;
        int                   start_cell;
        int                   goal_cell;
        bit                   goal_ok;
        bit                   stop;
        t_maze_result         res;
        found = 0;
        if (sr < GRID_ROWS && sc < GRID_COLS) begin
            goal_ok = goal_row_q < GRID_ROWS && goal_col_q < GRID_COLS;
            start_cell = int'(sr) * GRID_COLS + int'(sc);
            goal_cell = goal_ok ? int'(goal_row_q) * GRID_COLS + int'(goal_col_q) : 0;
            if (goal_ok && start_cell == goal_cell) begin
                found = 1;
            end else begin
                depth = 0;
                cell_at[0] = start_cell;
                dir_at[0] = DIR_UP;
                on_walk = '0;
                on_walk[start_cell] = 1'b1;
                stop = 1'b0;
                while (!stop) begin
                    cur = cell_at[depth];
                    dir = dir_at[depth];
                    if (dir >= DIR_END) begin
                        // all moves tried here: back out
                        on_walk[cur] = 1'b0;
                        if (depth == 0) stop = 1'b1;
                        else depth--;
                    end else begin
                        dir_at[depth] = dir + 1'b1;
                        r = cur / GRID_COLS;
                        c = cur % GRID_COLS;
                        case (dir)
                            DIR_UP:   r--;
                            DIR_DOWN: r++;
                            DIR_LEFT: c--;
                            default:  c++;
                        endcase
                        if (r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS) begin
                            nxt = r * GRID_COLS + c;
                            if (!(nxt < WALL_BITS && wall_q[nxt]) && !on_walk[nxt]) begin
                                if (goal_ok && nxt == goal_cell) begin
                                    found++;
                                    if (found >= int'(COUNT_MAX)) stop = 1'b1;
                                end else if (depth + 1 < CELL_COUNT) begin
                                    depth++;
                                    cell_at[depth] = nxt;
                                    dir_at[depth] = DIR_UP;
                                    on_walk[nxt] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
        res.paths = (found >= int'(COUNT_MAX)) ? COUNT_MAX : found[COUNT_W-1:0];
        res.sat = found >= int'(COUNT_MAX);
        return res;
    endfunction

    // lower start and wait until the block has nothing in flight
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (counts_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    // one register beat, only issued once the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WALL_MAP: wall_q = data[WALL_BITS-1:0];
            CFG_GOAL_ROW: goal_row_q = data[GOAL_W-1:0];
            CFG_GOAL_COL: goal_col_q = data[GOAL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // present one start cell and hold it until the block takes the beat
    task automatic send_cmd(input logic [1:0] sr, input logic [1:0] sc,
                            input logic known, input t_maze_result want);
        @(negedge i_clk);
        start <= 1'b1;
        i_start_row <= sr;
        i_start_col <= sc;
        do @(posedge i_clk); while (busy);
        counts_due.push_back(known ? want : predict_paths(sr, sc));
    endtask

    // idle gap on the command side
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_maze_result due;
        if (i_rst_n && o_done) begin
            if (counts_due.size() == 0) begin
                errors++;
                if (errors <= SHOWN_MISMATCHES)
                    $display("%0t: unexpected result count=%0d sat=%0b",
                             $realtime, o_path_count, o_count_saturated);
            end else begin
                due = counts_due.pop_front();
                if (o_path_count !== due.paths || o_count_saturated !== due.sat) begin
                    errors++;
                    if (errors <= SHOWN_MISMATCHES)
                        $display("%0t: mismatch count exp=%0d got=%0d sat exp=%0b got=%0b",
                                 $realtime, due.paths, o_path_count, due.sat,
                                 o_count_saturated);
                end
            end
        end
    end

    // hard stop
    initial begin
        #500_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        int issued;
        int phase_len;
        int burst_left;
        int pick;
        int tries;
        bit no_gaps;
        bit first_phase;
        logic [1:0] sr;
        logic [1:0] sc;
        logic [1:0] goal_pick;
        logic [WALL_BITS-1:0] walls;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_start_row = '0;
        i_start_col = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        wall_q = WALL_RESET;
        goal_row_q = GOAL_ROW_RESET;
        goal_col_q = GOAL_COL_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_cmd(plan[i].sr, plan[i].sc, plan[i].known, plan[i].want);
        end

        // random phases: new maze, then a run of start cells
        issued = 0;
        first_phase = 1'b1;
        while (issued < RANDOM_ITEMS) begin
            if (first_phase || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0, 1:    walls = '0;
                    2:       walls = '1;
                    3, 4, 5, 6, 7, 8, 9: walls = WALL_BITS'($urandom & $urandom);
                    default: walls = WALL_BITS'($urandom);
                endcase
                write_reg(CFG_WALL_MAP, CFG_DATA_W'(walls));
            end
            if (first_phase || $urandom_range(0, 3) != 0) begin
                goal_pick = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                write_reg(CFG_GOAL_ROW, {7'($urandom), goal_pick});
            end
            if (first_phase || $urandom_range(0, 3) != 0) begin
                goal_pick = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                write_reg(CFG_GOAL_COL, {7'($urandom), goal_pick});
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            first_phase = 1'b0;

            phase_len = $urandom_range(10, 50);
            no_gaps = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 10);
            for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++) begin
                // mostly open cells on the grid, some anywhere in the field range
                if ($urandom_range(0, 9) < 8) begin
                    pick = $urandom_range(0, CELL_COUNT - 1);
                    for (tries = 0; tries < 8 && wall_q[pick]; tries++)
                        pick = $urandom_range(0, CELL_COUNT - 1);
                    sr = 2'(pick / GRID_COLS);
                    sc = 2'(pick % GRID_COLS);
                end else begin
                    sr = 2'($urandom_range(0, 3));
                    sc = 2'($urandom_range(0, 3));
                end
                send_cmd(sr, sc, 1'b0, '0);
                issued++;
                burst_left--;
                if (burst_left == 0) begin
                    if (!no_gaps) hold_off($urandom_range(1, 15));
                    burst_left = $urandom_range(1, 10);
                end
            end
        end

        // drain, then a short settle
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (counts_due.size() != 0) errors++;
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gmpc_pkg.sv
rtl/gmpc_useq.sv
rtl/grid_maze_path_counter_top.sv
dv/tb_top.sv
